/* rtl/hgme_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hgme_pkg
// Shared types, constants and the control store of the heightmap mesh emitter.
// ----------------------------------------------------------------------------
package hgme_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int MAX_ROWS  = 1024;
    localparam int CFG_W     = 11;
    localparam int POS_W     = 10;
    localparam int TEX_W     = 17;
    localparam int HGT_W     = 8;
    localparam int STEP_W    = 4;

    localparam logic [TEX_W-1:0] TEX_ONE  = 17'h10000;
    localparam logic [CFG_W-1:0] DIM_MIN  = 11'd2;
    localparam logic [CFG_W-1:0] WIDTH_MAX = CFG_W'(MAX_WIDTH);
    localparam logic [CFG_W-1:0] ROWS_MAX  = CFG_W'(MAX_ROWS);
    localparam logic [CFG_W-1:0] DIM_RESET = 11'd2;

    // register index decoded from paddr[2]
    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    // height source select
    localparam logic [1:0] H_UPLEFT = 2'd0;
    localparam logic [1:0] H_UP     = 2'd1;
    localparam logic [1:0] H_LEFT   = 2'd2;
    localparam logic [1:0] H_CUR    = 2'd3;

    // program steps
    localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_CHECK  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_VTX0   = 4'd2;
    localparam logic [STEP_W-1:0] STEP_VTX1   = 4'd3;
    localparam logic [STEP_W-1:0] STEP_VTX2   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_VTX3   = 4'd5;
    localparam logic [STEP_W-1:0] STEP_VTX4   = 4'd6;
    localparam logic [STEP_W-1:0] STEP_VTX5   = 4'd7;
    localparam logic [STEP_W-1:0] STEP_UPDATE = 4'd8;

    typedef struct packed {
        logic              wait_in;
        logic              skip_nocell;
        logic              emit;
        logic              x_hi;
        logic              z_hi;
        logic [1:0]        hsel;
        logic              last;
        logic              update;
        logic [STEP_W-1:0] target;
    } hgme_ctrl_t;

    typedef struct packed {
        hgme_ctrl_t word;
        logic       go;
        logic       accept;
    } hgme_cmd_t;

    typedef struct packed {
        logic quad_ready;
        logic out_free;
    } hgme_stat_t;

    function automatic hgme_ctrl_t hgme_rom(input logic [STEP_W-1:0] pc);
        hgme_ctrl_t w;
        w = '0;
        case (pc)
            STEP_IDLE:
            begin
                w.wait_in = 1'b1;
            end
            STEP_CHECK:
            begin
                w.skip_nocell = 1'b1;
                w.target      = STEP_UPDATE;
            end
            STEP_VTX0:
            begin
                w.emit = 1'b1;
                w.hsel = H_UPLEFT;
            end
            STEP_VTX1:
            begin
                w.emit = 1'b1;
                w.x_hi = 1'b1;
                w.hsel = H_UP;
            end
            STEP_VTX2:
            begin
                w.emit = 1'b1;
                w.z_hi = 1'b1;
                w.hsel = H_LEFT;
            end
            STEP_VTX3:
            begin
                w.emit = 1'b1;
                w.x_hi = 1'b1;
                w.hsel = H_UP;
            end
            STEP_VTX4:
            begin
                w.emit = 1'b1;
                w.x_hi = 1'b1;
                w.z_hi = 1'b1;
                w.hsel = H_CUR;
            end
            STEP_VTX5:
            begin
                w.emit = 1'b1;
                w.z_hi = 1'b1;
                w.hsel = H_LEFT;
                w.last = 1'b1;
            end
            default:
            begin
                w.update = 1'b1;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

/* rtl/hgme_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hgme_div
// Radix-2 restoring divider: quotient and remainder of 65536 by a 10-bit
// divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hgme_div
    import hgme_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [POS_W-1:0] divisor,
    output logic [TEX_W-1:0]      quo,
    output logic [POS_W-1:0]      rem,
    output logic                  done
);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic [POS_W-1:0] rem_reg, rem_next;
    logic [POS_W-1:0] dvs_reg, dvs_next;
    logic [TEX_W-1:0] quo_reg, quo_next;
    logic [POS_W:0]   trial;
    logic             ge;

    assign trial = {rem_reg, TEX_ONE[cnt_reg]};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = 5'(TEX_W - 1);
            rem_next = '0;
            quo_next = '0;
            dvs_next = divisor;
        end
        else if (run_reg)
        begin
            rem_next = ge ? POS_W'(trial - {1'b0, dvs_reg}) : trial[POS_W-1:0];
            quo_next = {quo_reg[TEX_W-2:0], ge};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign quo  = quo_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

/* rtl/hgme_sequencer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hgme_sequencer
// Step counter over the control store, with the input wait, the no-cell skip
// and the output back-pressure hold.
// ----------------------------------------------------------------------------
module hgme_sequencer
    import hgme_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       enable,
    input  wire logic       in_valid,
    input  wire hgme_stat_t stat,
    output logic            in_stall,
    output hgme_cmd_t       cmd
);

    logic [STEP_W-1:0] pc_reg, pc_next;
    hgme_ctrl_t        word;
    logic              accept;
    logic              go;

    assign word     = hgme_rom(pc_reg);
    assign in_stall = !(word.wait_in && enable);
    assign accept   = word.wait_in && enable && in_valid;

    always_comb
    begin
        if (word.wait_in)
        begin
            go = accept;
        end
        else if (word.emit)
        begin
            go = stat.out_free;
        end
        else
        begin
            go = 1'b1;
        end
    end

    always_comb
    begin
        pc_next = pc_reg;
        if (go)
        begin
            if (word.update || (word.skip_nocell && !stat.quad_ready))
            begin
                pc_next = word.target;
            end
            else
            begin
                pc_next = pc_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign cmd.word   = word;
    assign cmd.go     = go;
    assign cmd.accept = accept;

endmodule
`default_nettype wire

/* rtl/hgme_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hgme_datapath
// Line buffer, neighbor samples, grid counters, incremental texture
// coordinates and the vertex output register.
// ----------------------------------------------------------------------------
module hgme_datapath
    import hgme_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire hgme_cmd_t        cmd,
    input  wire logic             restart,
    input  wire logic [HGT_W-1:0] height_sample,
    input  wire logic [POS_W-1:0] dw,
    input  wire logic [POS_W-1:0] dh,
    input  wire logic [TEX_W-1:0] qu,
    input  wire logic [POS_W-1:0] ru,
    input  wire logic [TEX_W-1:0] qv,
    input  wire logic [POS_W-1:0] rv,
    input  wire logic             out_stall,
    output hgme_stat_t            stat,
    output logic                  out_valid,
    output logic [POS_W-1:0]      pos_x,
    output logic [POS_W-1:0]      pos_z,
    output logic [HGT_W-1:0]      height_raw,
    output logic [TEX_W-1:0]      tex_u,
    output logic [TEX_W-1:0]      tex_v,
    output logic                  last_of_cell,
    output logic                  last_of_mesh
);

    logic [HGT_W-1:0] line_mem [MAX_WIDTH];
    logic [HGT_W-1:0] up_reg;
    logic [HGT_W-1:0] sample_reg;

    logic [POS_W-1:0] col_reg, col_next;
    logic [POS_W-1:0] row_reg, row_next;
    logic [HGT_W-1:0] left_reg, left_next;
    logic [HGT_W-1:0] upleft_reg, upleft_next;
    logic [TEX_W-1:0] ucur_reg, ucur_next, uprev_reg, uprev_next;
    logic [POS_W-1:0] urem_reg, urem_next;
    logic [TEX_W-1:0] vcur_reg, vcur_next, vprev_reg, vprev_next;
    logic [POS_W-1:0] vrem_reg, vrem_next;

    logic             ovalid_reg, ovalid_next;
    logic [POS_W-1:0] ox_reg, oz_reg;
    logic [HGT_W-1:0] oh_reg;
    logic [TEX_W-1:0] ou_reg, ov_reg;
    logic             olc_reg, olm_reg;

    logic             fire;
    logic             col_end, row_end;
    logic [POS_W:0]   usum, vsum;
    logic             ucarry, vcarry;
    logic [HGT_W-1:0] hsel_val;

    assign col_end = col_reg == dw;
    assign row_end = row_reg == dh;
    assign fire    = cmd.go && cmd.word.emit;

    assign stat.quad_ready = (col_reg != '0) && (row_reg != '0);
    assign stat.out_free   = !ovalid_reg || !out_stall;

    // line buffer: read on accept, write back on update
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            up_reg     <= line_mem[col_reg];
            sample_reg <= height_sample;
        end
        if (cmd.go && cmd.word.update)
        begin
            line_mem[col_reg] <= sample_reg;
        end
    end

    assign usum   = {1'b0, urem_reg} + {1'b0, ru};
    assign ucarry = usum >= {1'b0, dw};
    assign vsum   = {1'b0, vrem_reg} + {1'b0, rv};
    assign vcarry = vsum >= {1'b0, dh};

    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        left_next   = left_reg;
        upleft_next = upleft_reg;
        ucur_next   = ucur_reg;
        uprev_next  = uprev_reg;
        urem_next   = urem_reg;
        vcur_next   = vcur_reg;
        vprev_next  = vprev_reg;
        vrem_next   = vrem_reg;
        if (restart)
        begin
            col_next    = '0;
            row_next    = '0;
            left_next   = '0;
            upleft_next = '0;
            ucur_next   = '0;
            uprev_next  = '0;
            urem_next   = '0;
            vcur_next   = '0;
            vprev_next  = '0;
            vrem_next   = '0;
        end
        else if (cmd.go && cmd.word.update)
        begin
            if (col_end)
            begin
                col_next    = '0;
                left_next   = '0;
                upleft_next = '0;
                ucur_next   = '0;
                uprev_next  = '0;
                urem_next   = '0;
                if (row_end)
                begin
                    row_next  = '0;
                    vcur_next = '0;
                    vprev_next = '0;
                    vrem_next = '0;
                end
                else
                begin
                    row_next   = row_reg + 1'b1;
                    vprev_next = vcur_reg;
                    vcur_next  = vcur_reg + qv + TEX_W'(vcarry);
                    vrem_next  = vcarry ? POS_W'(vsum - {1'b0, dh}) : vsum[POS_W-1:0];
                end
            end
            else
            begin
                col_next    = col_reg + 1'b1;
                left_next   = sample_reg;
                upleft_next = up_reg;
                uprev_next  = ucur_reg;
                ucur_next   = ucur_reg + qu + TEX_W'(ucarry);
                urem_next   = ucarry ? POS_W'(usum - {1'b0, dw}) : usum[POS_W-1:0];
            end
        end
    end

    always_comb
    begin
        case (cmd.word.hsel)
            H_UPLEFT: hsel_val = upleft_reg;
            H_UP:     hsel_val = up_reg;
            H_LEFT:   hsel_val = left_reg;
            H_CUR:    hsel_val = sample_reg;
            default:  hsel_val = sample_reg;
        endcase
    end

    always_comb
    begin
        if (fire)
        begin
            ovalid_next = 1'b1;
        end
        else
        begin
            ovalid_next = ovalid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            left_reg   <= '0;
            upleft_reg <= '0;
            ucur_reg   <= '0;
            uprev_reg  <= '0;
            urem_reg   <= '0;
            vcur_reg   <= '0;
            vprev_reg  <= '0;
            vrem_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            left_reg   <= left_next;
            upleft_reg <= upleft_next;
            ucur_reg   <= ucur_next;
            uprev_reg  <= uprev_next;
            urem_reg   <= urem_next;
            vcur_reg   <= vcur_next;
            vprev_reg  <= vprev_next;
            vrem_reg   <= vrem_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            ox_reg  <= cmd.word.x_hi ? col_reg : col_reg - 1'b1;
            oz_reg  <= cmd.word.z_hi ? row_reg : row_reg - 1'b1;
            ou_reg  <= cmd.word.x_hi ? ucur_reg : uprev_reg;
            ov_reg  <= cmd.word.z_hi ? vcur_reg : vprev_reg;
            oh_reg  <= hsel_val;
            olc_reg <= cmd.word.last;
            olm_reg <= cmd.word.last && col_end && row_end;
        end
    end

    assign out_valid    = ovalid_reg;
    assign pos_x        = ox_reg;
    assign pos_z        = oz_reg;
    assign height_raw   = oh_reg;
    assign tex_u        = ou_reg;
    assign tex_v        = ov_reg;
    assign last_of_cell = olc_reg;
    assign last_of_mesh = olm_reg;

`ifndef SYNTH
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> (!ovalid_reg || !out_stall))
        else $error("vertex loaded over a stalled item");
    a_mesh_in_cell: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!last_of_mesh || last_of_cell))
        else $error("mesh end without cell end");
    a_emit_needs_cell: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> stat.quad_ready)
        else $error("vertex emitted for an incomplete cell");
`endif

endmodule
`default_nettype wire

/* rtl/heightmap_grid_mesh_emitter_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// heightmap_grid_mesh_emitter_top
// Heightmap to triangle grid: six vertices per completed grid cell.
// ----------------------------------------------------------------------------
// Height samples enter in raster order, one item per handshake. A sample that
// completes a cell (column and row both nonzero) passes through these steps
// from accept to the next ready point: accept with line buffer read, cell
// check, six vertex steps, update; any other sample passes accept, cell check
// and update. The microcoded step sequence and the single output register set
// this order, and output stalls hold the vertex steps. Texture steps are kept
// as a reciprocal quotient and remainder per axis; after reset they are ready
// at once, and after any register write the block holds in_stall high while
// the bit-serial divider runs for width and then height. Any register write
// also restarts the frame at column and row zero.
// ----------------------------------------------------------------------------
module heightmap_grid_mesh_emitter_top
    import hgme_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [HGT_W-1:0] height_sample,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [POS_W-1:0]      pos_x,
    output logic [POS_W-1:0]      pos_z,
    output logic [HGT_W-1:0]      height_raw,
    output logic [TEX_W-1:0]      tex_u,
    output logic [TEX_W-1:0]      tex_v,
    output logic                  last_of_cell,
    output logic                  last_of_mesh
);

    localparam logic [1:0] DIVP_IDLE  = 2'd0;
    localparam logic [1:0] DIVP_START = 2'd1;
    localparam logic [1:0] DIVP_W     = 2'd2;
    localparam logic [1:0] DIVP_H     = 2'd3;

    logic [CFG_W-1:0] gw_reg, gw_next, gh_reg, gh_next;
    logic [1:0]       phase_reg, phase_next;
    logic [TEX_W-1:0] qu_reg, qu_next, qv_reg, qv_next;
    logic [POS_W-1:0] ru_reg, ru_next, rv_reg, rv_next;
    logic             cfg_wr;
    logic [CFG_W-1:0] w_eff, h_eff;
    logic [POS_W-1:0] dw, dh;
    logic             div_start;
    logic [POS_W-1:0] div_divisor;
    logic [TEX_W-1:0] div_quo;
    logic [POS_W-1:0] div_rem;
    logic             div_done;
    hgme_cmd_t        cmd;
    hgme_stat_t       stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_GRID_HEIGHT) ? {21'd0, gh_reg} : {21'd0, gw_reg};

    always_comb
    begin
        gw_next = gw_reg;
        gh_next = gh_reg;
        if (cfg_wr)
        begin
            if (paddr[2] == REG_GRID_WIDTH)
            begin
                gw_next = pwdata[CFG_W-1:0];
            end
            else
            begin
                gh_next = pwdata[CFG_W-1:0];
            end
        end
    end

    assign w_eff = (gw_reg < DIM_MIN) ? DIM_MIN : ((gw_reg > WIDTH_MAX) ? WIDTH_MAX : gw_reg);
    assign h_eff = (gh_reg < DIM_MIN) ? DIM_MIN : ((gh_reg > ROWS_MAX) ? ROWS_MAX : gh_reg);
    assign dw    = POS_W'(w_eff - 1'b1);
    assign dh    = POS_W'(h_eff - 1'b1);

    // recompute both reciprocals after any write, width first
    always_comb
    begin
        phase_next  = phase_reg;
        qu_next     = qu_reg;
        ru_next     = ru_reg;
        qv_next     = qv_reg;
        rv_next     = rv_reg;
        div_start   = 1'b0;
        div_divisor = dw;
        case (phase_reg)
            DIVP_START:
            begin
                div_start  = 1'b1;
                phase_next = DIVP_W;
            end
            DIVP_W:
            begin
                if (div_done)
                begin
                    qu_next     = div_quo;
                    ru_next     = div_rem;
                    div_start   = 1'b1;
                    div_divisor = dh;
                    phase_next  = DIVP_H;
                end
            end
            DIVP_H:
            begin
                if (div_done)
                begin
                    qv_next    = div_quo;
                    rv_next    = div_rem;
                    phase_next = DIVP_IDLE;
                end
            end
            default:
            begin
                phase_next = DIVP_IDLE;
            end
        endcase
        if (cfg_wr)
        begin
            phase_next = DIVP_START;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg    <= DIM_RESET;
            gh_reg    <= DIM_RESET;
            phase_reg <= DIVP_IDLE;
            qu_reg    <= TEX_ONE;
            ru_reg    <= '0;
            qv_reg    <= TEX_ONE;
            rv_reg    <= '0;
        end
        else
        begin
            gw_reg    <= gw_next;
            gh_reg    <= gh_next;
            phase_reg <= phase_next;
            qu_reg    <= qu_next;
            ru_reg    <= ru_next;
            qv_reg    <= qv_next;
            rv_reg    <= rv_next;
        end
    end

    hgme_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .divisor (div_divisor),
        .quo     (div_quo),
        .rem     (div_rem),
        .done    (div_done)
    );

    hgme_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .enable   (phase_reg == DIVP_IDLE),
        .in_valid (in_valid),
        .stat     (stat),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    hgme_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .restart       (cfg_wr),
        .height_sample (height_sample),
        .dw            (dw),
        .dh            (dh),
        .qu            (qu_reg),
        .ru            (ru_reg),
        .qv            (qv_reg),
        .rv            (rv_reg),
        .out_stall     (out_stall),
        .stat          (stat),
        .out_valid     (out_valid),
        .pos_x         (pos_x),
        .pos_z         (pos_z),
        .height_raw    (height_raw),
        .tex_u         (tex_u),
        .tex_v         (tex_v),
        .last_of_cell  (last_of_cell),
        .last_of_mesh  (last_of_mesh)
    );

`ifndef SYNTH
    a_accept_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> (phase_reg == DIVP_IDLE))
        else $error("item taken while reciprocals are stale");
    a_write_restarts_div: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> (phase_reg == DIVP_START))
        else $error("register write did not restart the divider");
`endif

endmodule
`default_nettype wire

/* dv/heightmap_grid_mesh_emitter_top_test.sv */
// ----------------------------------------------------------------------------
// heightmap_grid_mesh_emitter_top_test
// Self-checking bench for the heightmap to triangle grid emitter.
// ----------------------------------------------------------------------------
// Height samples are fed through a bursty driver. A local tessellation model
// turns every accepted item that completes a cell into its six expected
// vertices, and a monitor compares each vertex leaving the block field by
// field against the oldest expected one. Grid sizes change between phases
// over the APB port. The phases cover the reset size, a tall grid, clamped
// register values, and a run of small random grids. The output side stalls on
// its own pattern, with one long hold that backs the block up into its input.
// ----------------------------------------------------------------------------
module heightmap_grid_mesh_emitter_top_test;
    import hgme_pkg::*;

    localparam int LIMIT_CYCLES = 1_500_000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_AT      = 30;
    localparam int HOLD_CYCLES  = 400;
    localparam int TALL_ITEMS   = 24;
    localparam int RANDOM_ITEMS = 100;
    localparam int MAX_REPORTS  = 10;

    localparam logic [2:0] ADDR_GRID_WIDTH  = {REG_GRID_WIDTH, 2'b00};
    localparam logic [2:0] ADDR_GRID_HEIGHT = {REG_GRID_HEIGHT, 2'b00};

    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_z;
        logic [HGT_W-1:0] height_raw;
        logic [TEX_W-1:0] tex_u;
        logic [TEX_W-1:0] tex_v;
        logic             last_of_cell;
        logic             last_of_mesh;
    } vertex_t;

    logic             clk;
    logic             rst_n;
    logic             psel    = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite  = 1'b0;
    logic [2:0]       paddr   = '0;
    logic [31:0]      pwdata  = '0;
    logic [31:0]      prdata;
    logic             pready;
    logic             in_valid      = 1'b0;
    logic             in_stall;
    logic [HGT_W-1:0] height_sample = '0;
    logic             out_valid;
    logic             out_stall     = 1'b0;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_z;
    logic [HGT_W-1:0] height_raw;
    logic [TEX_W-1:0] tex_u;
    logic [TEX_W-1:0] tex_v;
    logic             last_of_cell;
    logic             last_of_mesh;

    heightmap_grid_mesh_emitter_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .height_sample (height_sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pos_x         (pos_x),
        .pos_z         (pos_z),
        .height_raw    (height_raw),
        .tex_u         (tex_u),
        .tex_v         (tex_v),
        .last_of_cell  (last_of_cell),
        .last_of_mesh  (last_of_mesh)
    );

    // tessellation model state
    logic [HGT_W-1:0] row_mem [MAX_WIDTH];
    logic [HGT_W-1:0] left_h;
    logic [HGT_W-1:0] upleft_h;
    int unsigned      col_cnt;
    int unsigned      row_cnt;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    vertex_t          vertex_q [$];
    logic [HGT_W-1:0] pending_heights [$];

    int          mismatch_count = 0;
    int          accept_count   = 0;
    int          cycle_count    = 0;
    int          burst_left     = 0;
    int          gap_left       = 0;
    int          run_left       = 0;
    int          hold_left      = 0;
    int          mode_left      = 0;
    int          stall_mode     = 0;
    bit          hold_done      = 1'b0;
    logic        stall_next;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
        if (v < 2)
            return 2;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic logic [TEX_W-1:0] tex_coord(input int unsigned pos,
                                                    input int unsigned dim);
        logic [63:0] q;
        q = ({32'd0, pos} << 16) / 64'(dim - 1);
        return q[TEX_W-1:0];
    endfunction

    function automatic logic [HGT_W-1:0] random_height();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return HGT_W'($urandom);
        endcase
    endfunction

    task automatic push_vertex(input int unsigned x, input int unsigned z,
                               input logic [HGT_W-1:0] h, input int unsigned w,
                               input int unsigned ht, input logic cell_end,
                               input logic mesh_end);
        vertex_t v;
        v.pos_x        = POS_W'(x);
        v.pos_z        = POS_W'(z);
        v.height_raw   = h;
        v.tex_u        = tex_coord(x, w);
        v.tex_v        = tex_coord(z, ht);
        v.last_of_cell = cell_end;
        v.last_of_mesh = mesh_end;
        vertex_q.push_back(v);
    endtask

    // advance the grid by one height item, queue the cell it completes
    task automatic tessellate_sample(input logic [HGT_W-1:0] s);
        int unsigned      w;
        int unsigned      ht;
        int unsigned      col;
        int unsigned      row;
        int unsigned      cx;
        int unsigned      cz;
        logic [HGT_W-1:0] up;
        logic             mesh_end;
        w   = eff_dim(width_reg, MAX_WIDTH);
        ht  = eff_dim(height_reg, MAX_ROWS);
        col = col_cnt;
        row = row_cnt;
        if (col >= w)
            col = w - 1;
        if (row >= ht)
            row = ht - 1;
        up = row_mem[col % MAX_WIDTH];
        if (col >= 1 && row >= 1)
        begin
            cx       = col - 1;
            cz       = row - 1;
            mesh_end = (col == w - 1) && (row == ht - 1);
            push_vertex(cx,     cz,     upleft_h, w, ht, 1'b0, 1'b0);
            push_vertex(cx + 1, cz,     up,       w, ht, 1'b0, 1'b0);
            push_vertex(cx,     cz + 1, left_h,   w, ht, 1'b0, 1'b0);
            push_vertex(cx + 1, cz,     up,       w, ht, 1'b0, 1'b0);
            push_vertex(cx + 1, cz + 1, s,        w, ht, 1'b0, 1'b0);
            push_vertex(cx,     cz + 1, left_h,   w, ht, 1'b1, mesh_end);
        end
        upleft_h                = up;
        row_mem[col % MAX_WIDTH] = s;
        left_h                  = s;
        if (col + 1 >= w)
        begin
            col_cnt  = 0;
            left_h   = '0;
            upleft_h = '0;
            row_cnt  = (row + 1 >= ht) ? 0 : row + 1;
        end
        else
        begin
            col_cnt = col + 1;
            row_cnt = row;
        end
    endtask

    // setup and access cycle; the register takes the value at the last edge
    task automatic cfg_write(input logic [2:0] addr, input logic [CFG_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {(32 - CFG_W)'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_GRID_WIDTH)
            width_reg = value;
        else
            height_reg = value;
        // any write restarts the frame
        col_cnt  = 0;
        row_cnt  = 0;
        left_h   = '0;
        upleft_h = '0;
    endtask

    task automatic wait_idle();
        while (pending_heights.size() != 0 || in_valid || vertex_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic check_vertex(input vertex_t got);
        vertex_t want;
        if (vertex_q.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("unexpected vertex: x=%0d z=%0d h=%0d u=%0d v=%0d cell=%0b mesh=%0b",
                         got.pos_x, got.pos_z, got.height_raw, got.tex_u, got.tex_v,
                         got.last_of_cell, got.last_of_mesh);
        end
        else
        begin
            want = vertex_q.pop_front();
            if (got.pos_x !== want.pos_x || got.pos_z !== want.pos_z ||
                got.height_raw !== want.height_raw || got.tex_u !== want.tex_u ||
                got.tex_v !== want.tex_v || got.last_of_cell !== want.last_of_cell ||
                got.last_of_mesh !== want.last_of_mesh)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                begin
                    $display("vertex mismatch expected: x=%0d z=%0d h=%0d u=%0d v=%0d cell=%0b mesh=%0b",
                             want.pos_x, want.pos_z, want.height_raw, want.tex_u,
                             want.tex_v, want.last_of_cell, want.last_of_mesh);
                    $display("                actual:   x=%0d z=%0d h=%0d u=%0d v=%0d cell=%0b mesh=%0b",
                             got.pos_x, got.pos_z, got.height_raw, got.tex_u, got.tex_v,
                             got.last_of_cell, got.last_of_mesh);
                end
            end
        end
    endtask

    // driver: bursts of items with random gaps; hold the item while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            height_sample <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                tessellate_sample(height_sample);
                accept_count <= accept_count + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0)
                begin
                    gap_left = gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_heights.size() != 0)
                begin
                    in_valid      <= 1'b1;
                    height_sample <= pending_heights.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                    else
                        burst_left = burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern, with one long hold while the sender keeps going
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            run_left  = 0;
            hold_left = 0;
            mode_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(50, 300);
            end
            else
                mode_left = mode_left - 1;

            if (hold_left != 0)
            begin
                hold_left = hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (!hold_done && accept_count >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else if (run_left != 0)
                run_left = run_left - 1;
            else
            begin
                case (stall_mode)
                    0:
                    begin
                        stall_next = 1'b0;
                        run_left   = $urandom_range(4, 30);
                    end
                    1:
                    begin
                        stall_next = ($urandom_range(0, 3) == 0);
                        run_left   = $urandom_range(0, 2);
                    end
                    2:
                    begin
                        stall_next = $urandom_range(0, 1);
                        run_left   = $urandom_range(0, 4);
                    end
                    default:
                    begin
                        stall_next = ($urandom_range(0, 3) != 0);
                        run_left   = $urandom_range(0, 7);
                    end
                endcase
                out_stall <= stall_next;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            check_vertex('{pos_x, pos_z, height_raw, tex_u, tex_v,
                           last_of_cell, last_of_mesh});
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int unsigned      w_eff;
        int unsigned      h_eff;
        int unsigned      n;
        int unsigned      random_sent;
        logic [CFG_W-1:0] wv;
        logic [CFG_W-1:0] hv;

        for (int i = 0; i < MAX_WIDTH; i++)
            row_mem[i] = '0;
        left_h     = '0;
        upleft_h   = '0;
        col_cnt    = 0;
        row_cnt    = 0;
        width_reg  = DIM_RESET;
        height_reg = DIM_RESET;

        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset size 2x2: one cell, then a second grid after the wrap
        pending_heights = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'hFF, 8'h00, 8'h0F, 8'hF0};
        wait_idle();

        // 3x3 grid, then stop two items into the next frame
        cfg_write(ADDR_GRID_WIDTH, 11'd3);
        cfg_write(ADDR_GRID_HEIGHT, 11'd3);
        pending_heights = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hFE, 8'h7F,
                            8'hFF, 8'h00, 8'hC3, 8'h5A, 8'hA5};
        wait_idle();

        // values below the range clamp up to 2
        cfg_write(ADDR_GRID_WIDTH, 11'd0);
        cfg_write(ADDR_GRID_HEIGHT, 11'd1);
        pending_heights = '{8'hFF, 8'hFF, 8'h00, 8'hFF};
        wait_idle();

        // tallest grid, two columns, first rows only
        cfg_write(ADDR_GRID_WIDTH, 11'd2);
        cfg_write(ADDR_GRID_HEIGHT, ROWS_MAX);
        for (int i = 0; i < TALL_ITEMS; i++)
            pending_heights.push_back(random_height());
        wait_idle();

        // both registers above range clamp down to the maximum
        cfg_write(ADDR_GRID_HEIGHT, 11'h7FF);
        cfg_write(ADDR_GRID_WIDTH, 11'd1500);
        for (int i = 0; i < 4; i++)
            pending_heights.push_back(random_height());
        wait_idle();
        cfg_write(ADDR_GRID_WIDTH, 11'd2);
        for (int i = 0; i < 10; i++)
            pending_heights.push_back(random_height());
        wait_idle();

        // small random grids
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            wv = CFG_W'($urandom_range(0, 9));
            hv = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(1025, 2047))
                                             : CFG_W'($urandom_range(0, 6));
            case ($urandom_range(0, 3))
                0:
                    cfg_write(ADDR_GRID_WIDTH, wv);
                1:
                begin
                    cfg_write(ADDR_GRID_HEIGHT, hv);
                    cfg_write(ADDR_GRID_WIDTH, wv);
                end
                default:
                begin
                    cfg_write(ADDR_GRID_WIDTH, wv);
                    cfg_write(ADDR_GRID_HEIGHT, hv);
                end
            endcase
            w_eff = eff_dim(width_reg, MAX_WIDTH);
            h_eff = eff_dim(height_reg, MAX_ROWS);
            n = $urandom_range(4, (2 * w_eff * h_eff + 2 > 40) ? 40
                                                                : 2 * w_eff * h_eff + 2);
            for (int i = 0; i < n; i++)
                pending_heights.push_back(random_height());
            random_sent += n;
            wait_idle();
        end

        if (mismatch_count == 0 && vertex_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
